// ===== rtl/dcws_pkg.sv =====
// shared constants, types and helpers for the deduplicating cell work stack
// no dependencies

package dcws_pkg;

	localparam int GRID_ROWS  = 64;
	localparam int GRID_COLS  = 64;
	localparam int STAMP_BITS = 16;

	localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
	localparam int CELL_W     = $clog2(CELL_COUNT);
	localparam int FILL_W     = CELL_W + 1;
	localparam int COORD_W    = 6;
	localparam int ENTRY_W    = 2 * COORD_W;

	typedef logic [CELL_W-1:0]     cell_idx_t;
	typedef logic [FILL_W-1:0]     fill_t;
	typedef logic [STAMP_BITS-1:0] stamp_t;
	typedef logic [COORD_W-1:0]    coord_t;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [1:0] {
		PS_STORED = 2'd0,
		PS_DUP    = 2'd1,
		PS_FULL   = 2'd2
	} push_status_t;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	// coordinate reduced modulo a grid dimension by restoring subtraction
	function automatic coord_t coord_mod(input coord_t v, input int dim);
		coord_t r;
		r = v;
		for (int k = COORD_W - 1; k >= 0; k--) begin
			if (int'(r) >= (dim << k)) begin
				r = r - COORD_W'(dim << k);
			end
		end
		return r;
	endfunction

	function automatic cell_idx_t cell_index(input coord_t row, input coord_t col);
		return CELL_W'(int'(row) * GRID_COLS + int'(col));
	endfunction

endpackage

// ===== rtl/dedup_cell_work_stack.sv =====
// top level of the deduplicating cell work stack
// depends on dcws_pkg and dcws_ram

// A lifo work list of grid cells with duplicate suppression by generation
// stamps. A command beat is taken when start is high and busy is low. Each
// beat produces exactly one result beat, shown for one cycle with done high
// once the execute state has registered it; the receiver cannot stall, so the
// result must be captured in that cycle. The stamp memory and the stack memory
// are read in the accept cycle and the registered read data is checked and
// written back in the next cycle, during which busy is high. After reset the
// stamp memory is swept to zero, one entry per cycle, across all entries
// (GRID_ROWS*GRID_COLS, 4096 at 64 by 64) while busy stays high. Push results:
// push_status stored, duplicate (stamp already equals generation, checked
// first) or full (dropped, stamp unchanged). A pop returns the top cell, or
// was_empty with zero coordinates. Coordinates are reduced modulo the grid
// size and the generation is cut to the stamp width.

module dedup_cell_work_stack
	import dcws_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [5:0]  cell_row,
	input  logic [5:0]  cell_col,
	input  logic [15:0] generation,
	output logic        done,
	output logic [5:0]  out_row,
	output logic [5:0]  out_col,
	output logic        was_empty,
	output logic [1:0]  push_status
);

	state_t    state_q;
	cell_idx_t clr_q;
	fill_t     fill_q;

	// command captured at accept
	logic      op_s1;
	coord_t    row_s1;
	coord_t    col_s1;
	cell_idx_t cell_s1;
	stamp_t    gen_s1;

	// result register
	logic         done_q;
	coord_t       out_row_q;
	coord_t       out_col_q;
	logic         was_empty_q;
	push_status_t push_status_q;

	logic      accept;
	coord_t    row_in;
	coord_t    col_in;
	cell_idx_t cell_in;
	fill_t     fill_m1;

	logic                stamp_we;
	cell_idx_t           stamp_waddr;
	stamp_t              stamp_wdata;
	stamp_t              stamp_rdata;
	logic                stack_we;
	logic [ENTRY_W-1:0]  stack_rdata;

	logic dup_hit;
	logic full;
	logic empty;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign row_in  = coord_mod(cell_row, GRID_ROWS);
	assign col_in  = coord_mod(cell_col, GRID_COLS);
	assign cell_in = cell_index(row_in, col_in);
	assign fill_m1 = fill_q - FILL_W'(1);

	assign dup_hit = (stamp_rdata == gen_s1);
	assign full    = (fill_q == FILL_W'(CELL_COUNT));
	assign empty   = (fill_q == '0);

	// stamp port: zero sweep after reset, else write-back of a stored push
	always_comb begin
		stamp_we    = 1'b0;
		stamp_waddr = cell_s1;
		stamp_wdata = gen_s1;
		if (state_q == ST_CLEAR) begin
			stamp_we    = 1'b1;
			stamp_waddr = clr_q;
			stamp_wdata = '0;
		end else if (state_q == ST_EXEC && op_s1 == OP_PUSH && !dup_hit && !full) begin
			stamp_we = 1'b1;
		end
	end

	assign stack_we = (state_q == ST_EXEC) && (op_s1 == OP_PUSH) && !dup_hit && !full;

	dcws_ram #(
		.WIDTH(STAMP_BITS),
		.DEPTH(CELL_COUNT)
	) u_stamp_ram (
		.clk   (clk),
		.we    (stamp_we),
		.waddr (stamp_waddr),
		.wdata (stamp_wdata),
		.raddr (cell_in),
		.rdata (stamp_rdata)
	);

	// stack slots; the pop read address is the top entry at accept time
	dcws_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CELL_COUNT)
	) u_stack_ram (
		.clk   (clk),
		.we    (stack_we),
		.waddr (fill_q[CELL_W-1:0]),
		.wdata ({row_s1, col_s1}),
		.raddr (fill_m1[CELL_W-1:0]),
		.rdata (stack_rdata)
	);

	// control: clear sweep, idle, and an execute state per command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			fill_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CELL_W'(1);
					if (clr_q == CELL_W'(CELL_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					if (op_s1 == OP_PUSH) begin
						if (!dup_hit && !full) begin
							fill_q <= fill_q + FILL_W'(1);
						end
					end else if (!empty) begin
						fill_q <= fill_m1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command capture, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= opcode;
			row_s1  <= row_in;
			col_s1  <= col_in;
			cell_s1 <= cell_in;
			gen_s1  <= STAMP_BITS'(generation);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			out_row_q     <= '0;
			out_col_q     <= '0;
			was_empty_q   <= 1'b0;
			push_status_q <= PS_STORED;
			if (op_s1 == OP_PUSH) begin
				if (dup_hit) begin
					push_status_q <= PS_DUP;
				end else if (full) begin
					push_status_q <= PS_FULL;
				end
			end else if (empty) begin
				was_empty_q <= 1'b1;
			end else begin
				out_row_q <= stack_rdata[ENTRY_W-1:COORD_W];
				out_col_q <= stack_rdata[COORD_W-1:0];
			end
		end
	end

	assign done        = done_q;
	assign out_row     = out_row_q;
	assign out_col     = out_col_q;
	assign was_empty   = was_empty_q;
	assign push_status = push_status_q;

	// every accepted command yields a done result after its execute state
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("accepted command produced no result");

	// a result only leaves the execute cycle
	a_done_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_EXEC))
		else $error("result without execute cycle");

	// fill count never passes capacity
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(CELL_COUNT))
		else $error("fill count beyond capacity");

	// an empty pop carries no coordinates and no push outcome
	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && was_empty) |-> (out_row == '0 && out_col == '0 && push_status == PS_STORED))
		else $error("empty pop with payload");

endmodule

// ===== rtl/dcws_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies

module dcws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sim/tb_dedup_cell_work_stack.sv =====
// self-checking testbench for dedup_cell_work_stack: directed, capacity and random traffic
// depends on dcws_pkg and the dedup_cell_work_stack rtl; a mirror of the stack and
// stamp store predicts every result beat

module tb_dedup_cell_work_stack;
	import dcws_pkg::*;

	// one expected result beat
	typedef struct {
		coord_t       row;
		coord_t       col;
		logic         empty;
		push_status_t status;
	} cell_outcome_t;

	// mirror of the lifo and the per-cell generation stamps, plus the queue of
	// outcomes still owed by the block
	class work_stack_mirror;
		coord_t        stacked_rows [CELL_COUNT];
		coord_t        stacked_cols [CELL_COUNT];
		stamp_t        stamps [CELL_COUNT];
		int            depth;
		int            failures;
		cell_outcome_t owed_outcomes [$];

		function new();
			for (int i = 0; i < CELL_COUNT; i++) begin
				stacked_rows[i] = '0;
				stacked_cols[i] = '0;
				stamps[i]       = '0;
			end
			depth    = 0;
			failures = 0;
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= 10) begin
				$display("%s", msg);
			end
		endfunction

		// accepted command beat: update the mirror and queue the outcome
		function void note_command(logic op, coord_t row, coord_t col, logic [15:0] gen);
			cell_outcome_t o;
			coord_t        r;
			coord_t        c;
			stamp_t        g;
			int            idx;
			r        = coord_t'(int'(row) % GRID_ROWS);
			c        = coord_t'(int'(col) % GRID_COLS);
			g        = stamp_t'(gen);
			idx      = int'(r) * GRID_COLS + int'(c);
			o.row    = '0;
			o.col    = '0;
			o.empty  = 1'b0;
			o.status = PS_STORED;
			if (op == OP_PUSH) begin
				// duplicate check wins over the full check
				if (stamps[idx] == g) begin
					o.status = PS_DUP;
				end else if (depth >= CELL_COUNT) begin
					o.status = PS_FULL;
				end else begin
					stacked_rows[depth] = r;
					stacked_cols[depth] = c;
					depth++;
					stamps[idx] = g;
				end
			end else if (depth == 0) begin
				o.empty = 1'b1;
			end else begin
				depth--;
				o.row = stacked_rows[depth];
				o.col = stacked_cols[depth];
			end
			owed_outcomes.push_back(o);
		endfunction

		// result beat: compare against the oldest owed outcome
		function void check_result(coord_t row, coord_t col, logic empty, logic [1:0] status);
			cell_outcome_t o;
			if (owed_outcomes.size() == 0) begin
				flag($sformatf("unexpected result: row %0d col %0d empty %0b status %0d",
					row, col, empty, status));
				return;
			end
			o = owed_outcomes.pop_front();
			if (row !== o.row || col !== o.col || empty !== o.empty ||
					status !== 2'(o.status)) begin
				flag($sformatf({"mismatch: expected row %0d col %0d empty %0b status %0d,",
					" got row %0d col %0d empty %0b status %0d"},
					o.row, o.col, o.empty, o.status, row, col, empty, status));
			end
		endfunction

		function int outstanding();
			return owed_outcomes.size();
		endfunction

		function bit stamp_in_use(stamp_t g);
			foreach (stamps[i]) begin
				if (stamps[i] == g) begin
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        opcode = OP_PUSH;
	logic [5:0]  cell_row = '0;
	logic [5:0]  cell_col = '0;
	logic [15:0] generation = '0;
	logic        done;
	logic [5:0]  out_row;
	logic [5:0]  out_col;
	logic        was_empty;
	logic [1:0]  push_status;

	work_stack_mirror tracker = new();

	// chance in percent that the sender idles before a beat, and that it keeps idling
	int idle_pct = 0;

	dedup_cell_work_stack uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.generation (generation),
		.done       (done),
		.out_row    (out_row),
		.out_col    (out_col),
		.was_empty  (was_empty),
		.push_status(push_status)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// monitor: command beats are taken on start && !busy, result beats on done;
	// both sampled with their pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				tracker.note_command(opcode, cell_row, cell_col, generation);
			end
			if (done) begin
				tracker.check_result(out_row, out_col, was_empty, push_status);
			end
		end
	end

	// one command beat; start is left high so the next beat can follow back to back
	task automatic send_command(input logic op, input coord_t row, input coord_t col,
			input logic [15:0] gen);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start      <= 1'b1;
		opcode     <= op;
		cell_row   <= row;
		cell_col   <= col;
		generation <= gen;
		// busy read here is the pre-edge value, same as the monitor sees
		do @(posedge clk); while (busy);
	endtask

	// hold off until every owed result beat has come back, then settle
	task automatic wait_drained();
		start <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// well-formed work-list traffic: pushes mostly reuse a small pool of cells at
	// the current generation so duplicates are common, the generation advances
	// now and then, and a few pushes carry an arbitrary generation
	task automatic run_traffic(input int count, input int pct);
		coord_t      pool_r [16];
		coord_t      pool_c [16];
		logic [15:0] cur_gen;
		logic [15:0] g;
		coord_t      r;
		coord_t      c;
		int          k;
		int          pick;
		idle_pct = pct;
		foreach (pool_r[i]) begin
			pool_r[i] = coord_t'($urandom);
			pool_c[i] = coord_t'($urandom);
		end
		cur_gen = 16'($urandom);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) == 0) begin
				wait_drained();
			end
			if ($urandom_range(99) < 45) begin
				// row, column and generation are don't-cares on a pop
				send_command(OP_POP, coord_t'($urandom), coord_t'($urandom), 16'($urandom));
			end else begin
				if ($urandom_range(99) < 60) begin
					k = $urandom_range(15);
					r = pool_r[k];
					c = pool_c[k];
				end else begin
					r = coord_t'($urandom);
					c = coord_t'($urandom);
				end
				pick = $urandom_range(99);
				if (pick < 8) begin
					cur_gen++;
				end
				g = (pick < 95) ? cur_gen : 16'($urandom);
				send_command(OP_PUSH, r, c, g);
			end
		end
	endtask

	initial begin
		stamp_t fill_gen;
		int     stride;
		int     offset;
		int     slot;
		int     n;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: the first beat waits out the stamp clearing sweep
		send_command(OP_POP, 6'd63, 6'd63, 16'hFFFF);   // pop on empty stack
		send_command(OP_PUSH, 6'd0, 6'd0, 16'h0000);    // generation zero on fresh stamp: dup
		send_command(OP_PUSH, 6'd63, 6'd63, 16'hFFFF);
		send_command(OP_PUSH, 6'd63, 6'd63, 16'hFFFF);  // same generation again: dup
		send_command(OP_PUSH, 6'd0, 6'd0, 16'h0001);
		send_command(OP_PUSH, 6'd21, 6'd42, 16'h5555);
		send_command(OP_PUSH, 6'd42, 6'd21, 16'hAAAA);
		send_command(OP_PUSH, 6'd0, 6'd63, 16'h8000);
		send_command(OP_PUSH, 6'd63, 6'd0, 16'h7FFF);
		repeat (6) send_command(OP_POP, 6'd0, 6'd0, 16'h0000);
		send_command(OP_POP, 6'd42, 6'd21, 16'h1234);   // empty again
		// a popped cell keeps its stamp; a new generation stacks it again
		send_command(OP_PUSH, 6'd63, 6'd63, 16'hFFFE);
		send_command(OP_PUSH, 6'd63, 6'd63, 16'hFFFF);
		repeat (3) send_command(OP_POP, 6'd63, 6'd63, 16'hFFFF);
		wait_drained();

		run_traffic(475, 0);
		wait_drained();
		run_traffic(475, 50);
		wait_drained();

		// capacity: empty the stack, then push every cell once with a generation
		// no cell carries yet, in a scrambled order
		idle_pct = 0;
		n = tracker.depth;
		repeat (n) send_command(OP_POP, 6'd0, 6'd0, 16'h0000);
		wait_drained();
		fill_gen = stamp_t'($urandom);
		while (tracker.stamp_in_use(fill_gen)) fill_gen++;
		stride = 2 * $urandom_range(CELL_COUNT / 2 - 1) + 1;
		offset = $urandom_range(CELL_COUNT - 1);
		for (int i = 0; i < CELL_COUNT; i++) begin
			slot = (i * stride + offset) % CELL_COUNT;
			send_command(OP_PUSH, coord_t'(slot / GRID_COLS), coord_t'(slot % GRID_COLS),
				16'(fill_gen));
		end
		// stack is full: a duplicate still reports dup, anything else is dropped
		send_command(OP_PUSH, 6'd5, 6'd9, 16'(fill_gen));
		send_command(OP_PUSH, 6'd5, 6'd9, 16'(fill_gen ^ 1'b1));
		repeat (6) send_command(OP_PUSH, coord_t'($urandom), coord_t'($urandom), 16'($urandom));
		// unwind the whole stack in lifo order, plus one pop past the bottom
		repeat (CELL_COUNT + 1) send_command(OP_POP, coord_t'($urandom), coord_t'($urandom),
			16'($urandom));
		wait_drained();

		run_traffic(475, 0);
		wait_drained();
		run_traffic(475, 17);

		// end of stimulus: let the last beats come back, then settle and report
		start <= 1'b0;
		for (int w = 0; w < 1000 && tracker.outstanding() != 0; w++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.outstanding() != 0) begin
			tracker.flag($sformatf("%0d result beats never arrived", tracker.outstanding()));
		end
		if (tracker.failures == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#1000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/dcws_pkg.sv
rtl/dcws_ram.sv
rtl/dedup_cell_work_stack.sv
sim/tb_dedup_cell_work_stack.sv
